// ----- hw/rtl/alf_pkg.sv -----
package alf_pkg;

    localparam int NUM_W      = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int STEP_CNT_W = $clog2(NUM_W);

    localparam int MAX_HEADING_CHARS = 16;
    localparam int HEAD_LEN_W        = 5;
    localparam int HEAD_IDX_W        = 4;
    localparam int HEAD_BITS         = 8 * 16;
    localparam int WRAP_W            = 7;
    localparam int LINE_W            = 8;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    localparam logic [WRAP_W-1:0] WRAP_RESET = 7'd78;

    typedef enum logic [1:0] {
        REG_HEAD_LO  = 2'd0,
        REG_HEAD_HI  = 2'd1,
        REG_HEAD_LEN = 2'd2,
        REG_WRAP     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [HEAD_BITS-1:0]  head_chars;
        logic [HEAD_LEN_W-1:0] head_len;
        logic [WRAP_W-1:0]     wrap;
    } cfg_t;

    typedef struct packed {
        logic wrap_cr;
        logic head;
        logic space;
        logic net;
        logic node;
        logic end_cr;
    } plan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_PLAN,
        S_WRAP_CR,
        S_HEAD,
        S_SPACE,
        S_NET,
        S_SLASH,
        S_NODE,
        S_END_CR
    } state_t;

endpackage

// ----- hw/rtl/alf_pair_if.sv -----
interface alf_pair_if import alf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [NUM_W-1:0] net_number;
    logic [NUM_W-1:0] node_number;
    logic             last_pair;

    modport source (output valid, kind, net_number, node_number, last_pair, input ready);
    modport sink   (input valid, kind, net_number, node_number, last_pair, output ready);
endinterface

// ----- hw/rtl/alf_char_if.sv -----
interface alf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_item;
    logic       end_of_text;

    modport source (output valid, out_char, last_of_item, end_of_text, input ready);
    modport sink   (input valid, out_char, last_of_item, end_of_text, output ready);
endinterface

// ----- hw/rtl/alf_cfg.sv -----
module alf_cfg import alf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [63:0]           head_lo_reg;
    logic [63:0]           head_hi_reg;
    logic [HEAD_LEN_W-1:0] head_len_reg;
    logic [WRAP_W-1:0]     wrap_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_lo_reg  <= '0;
            head_hi_reg  <= '0;
            head_len_reg <= '0;
            wrap_reg     <= WRAP_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_HEAD_LO:  head_lo_reg  <= pwdata;
                REG_HEAD_HI:  head_hi_reg  <= pwdata;
                REG_HEAD_LEN: head_len_reg <= pwdata[HEAD_LEN_W-1:0];
                REG_WRAP:     wrap_reg     <= pwdata[WRAP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HEAD_LO:  prdata = head_lo_reg;
            REG_HEAD_HI:  prdata = head_hi_reg;
            REG_HEAD_LEN: prdata = {{(CFG_DATA_W-HEAD_LEN_W){1'b0}}, head_len_reg};
            REG_WRAP:     prdata = {{(CFG_DATA_W-WRAP_W){1'b0}}, wrap_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.head_chars = {head_hi_reg, head_lo_reg};
    assign cfg.head_len   = head_len_reg;
    assign cfg.wrap       = wrap_reg;

endmodule

// ----- hw/rtl/address_list_line_formatter_top.sv -----
// Channel  | Dir | Beat contents                              | Accepted when
// ---------+-----+--------------------------------------------+---------------------
// pairs    | in  | kind, net_number, node_number, last_pair   | valid && ready
// chars    | out | out_char, last_of_item, end_of_text        | valid && ready
// APB      | in  | heading words, heading length, wrap limit  | psel&penable&pwrite
//
// An address pair is accepted, converted from binary to decimal (one shared
// shift-and-add-3 step per bit, net then node), planned, and then emitted one
// character per cycle while chars is not stalled.
// An empty-list beat skips conversion and emits only the heading, if any, and a CR.
// Reset clears the sequencer, the line state and the output valid flag at once.
// A stall on chars holds the current character and freezes the emitting sequencer;
// pairs.ready is high only while the block is idle.
module address_list_line_formatter_top import alf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    alf_pair_if.sink              pairs,
    alf_char_if.source            chars,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    cfg_t cfg;

    alf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer state and item registers
    state_t                state_reg, state_next;
    plan_t                 plan_reg, plan_next;
    logic                  kind_reg;
    logic                  last_reg;
    logic [NUM_W-1:0]      net_reg;
    logic [NUM_W-1:0]      node_reg;

    // Shared conversion unit: shift register, BCD accumulator, bit counter
    logic [NUM_W-1:0]      shift_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_step;
    logic [BCD_W-1:0]      net_bcd_reg;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    logic                  conv_sel_reg;

    // Line state kept between items
    logic [NUM_W-1:0]      prev_net_reg, prev_net_next;
    logic [LINE_W-1:0]     line_len_reg, line_len_next;
    logic                  at_start_reg, at_start_next;

    // Emission counters
    logic [HEAD_IDX_W-1:0] head_cnt_reg;
    logic [2:0]            dig_cnt_reg;

    // Output register
    logic                  out_valid_reg;
    logic [7:0]            out_char_reg;
    logic                  out_last_reg;
    logic                  out_eot_reg;

    logic                  in_fire;
    logic                  out_ok;
    logic                  emitting;
    logic                  seg_done;
    logic [7:0]            emit_char;
    logic                  emit_eot;
    logic [HEAD_LEN_W-1:0] head_used;
    logic [2:0]            net_len;
    logic [2:0]            node_len;
    logic [3:0]            full_len;
    logic [3:0]            tok_len;
    logic                  same_net;
    logic                  fits;
    logic [3:0]            net_digit;
    logic [3:0]            node_digit;

    // One double-dabble step: add 3 to every digit of five or more, then shift
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
        logic [BCD_W-1:0] t;
        t = b;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (t[4*d +: 4] >= 4'd5)
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [2:0] dec_len(input logic [BCD_W-1:0] b);
        logic [2:0] n;
        n = 3'd1;
        for (int d = 1; d < BCD_DIGITS; d++)
        begin
            if (b[4*d +: 4] != 4'd0)
                n = 3'(d + 1);
        end
        return n;
    endfunction

    // Position of an emitting state in the fixed output order; 0 for none
    function automatic logic [2:0] seg_ord(input state_t s);
        case (s)
            S_WRAP_CR: return 3'd1;
            S_HEAD:    return 3'd2;
            S_SPACE:   return 3'd3;
            S_NET:     return 3'd4;
            S_SLASH:   return 3'd5;
            S_NODE:    return 3'd6;
            S_END_CR:  return 3'd7;
            default:   return 3'd0;
        endcase
    endfunction

    function automatic state_t seg_state(input logic [2:0] ord);
        case (ord)
            3'd1:    return S_WRAP_CR;
            3'd2:    return S_HEAD;
            3'd3:    return S_SPACE;
            3'd4:    return S_NET;
            3'd5:    return S_SLASH;
            3'd6:    return S_NODE;
            3'd7:    return S_END_CR;
            default: return S_IDLE;
        endcase
    endfunction

    // First enabled segment after the given position, or idle
    function automatic state_t next_seg(input logic [2:0] from_ord, input plan_t p);
        logic [7:1] en;
        state_t     r;
        en = {p.end_cr, p.node, p.net, p.net, p.space, p.head, p.wrap_cr};
        r  = S_IDLE;
        for (int i = 7; i >= 1; i--)
        begin
            if (en[i] && (3'(i) > from_ord))
                r = seg_state(3'(i));
        end
        return r;
    endfunction

    assign pairs.ready = (state_reg == S_IDLE);
    assign in_fire     = pairs.valid && pairs.ready;
    assign out_ok      = !out_valid_reg || chars.ready;
    assign emitting    = (seg_ord(state_reg) != 3'd0);

    assign bcd_step  = dabble(bcd_reg, shift_reg[NUM_W-1]);
    assign head_used = (cfg.head_len > HEAD_LEN_W'(MAX_HEADING_CHARS))
                     ? HEAD_LEN_W'(MAX_HEADING_CHARS) : cfg.head_len;
    assign net_len   = dec_len(net_bcd_reg);
    assign node_len  = dec_len(bcd_reg);
    assign full_len  = {1'b0, net_len} + 4'd1 + {1'b0, node_len};
    assign same_net  = (net_reg == prev_net_reg);
    assign tok_len   = same_net ? (4'd1 + {1'b0, node_len}) : (4'd1 + full_len);
    assign fits      = ({1'b0, line_len_reg} + 9'(tok_len)) <= {2'b00, cfg.wrap};

    // Decide which pieces this item emits and what line state it leaves
    always_comb
    begin
        plan_next     = '0;
        prev_net_next = prev_net_reg;
        line_len_next = line_len_reg;
        at_start_next = at_start_reg;
        if (kind_reg)
        begin
            plan_next.head   = (head_used != '0);
            plan_next.end_cr = 1'b1;
            at_start_next    = 1'b1;
            line_len_next    = '0;
        end
        else
        begin
            if (at_start_reg || !fits)
            begin
                plan_next.wrap_cr = !at_start_reg;
                plan_next.head    = (head_used != '0);
                plan_next.net     = 1'b1;
                line_len_next     = LINE_W'(head_used) + LINE_W'(full_len);
            end
            else
            begin
                plan_next.space = 1'b1;
                plan_next.net   = !same_net;
                line_len_next   = line_len_reg + LINE_W'(tok_len);
            end
            plan_next.node = 1'b1;
            prev_net_next  = net_reg;
            at_start_next  = 1'b0;
            if (last_reg)
            begin
                plan_next.end_cr = 1'b1;
                at_start_next    = 1'b1;
                line_len_next    = '0;
            end
        end
    end

    // Last character of the current segment
    always_comb
    begin
        case (state_reg)
            S_HEAD:  seg_done = ({1'b0, head_cnt_reg} + 5'd1) == head_used;
            S_NET:   seg_done = (dig_cnt_reg == 3'd0);
            S_NODE:  seg_done = (dig_cnt_reg == 3'd0);
            default: seg_done = 1'b1;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = pairs.kind ? S_PLAN : S_CONV;
            end
            S_CONV:
            begin
                if (conv_sel_reg && (step_cnt_reg == STEP_CNT_W'(NUM_W - 1)))
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                state_next = next_seg(3'd0, plan_next);
            end
            default:
            begin
                if (out_ok && seg_done)
                    state_next = next_seg(seg_ord(state_reg), plan_reg);
            end
        endcase
    end

    assign net_digit  = 4'(net_bcd_reg >> {dig_cnt_reg, 2'b00});
    assign node_digit = 4'(bcd_reg >> {dig_cnt_reg, 2'b00});

    // Character of the current cycle
    always_comb
    begin
        emit_eot = 1'b0;
        case (state_reg)
            S_WRAP_CR: emit_char = CHAR_CR;
            S_HEAD:    emit_char = 8'(cfg.head_chars >> {head_cnt_reg, 3'b000});
            S_SPACE:   emit_char = CHAR_SPACE;
            S_NET:     emit_char = CHAR_ZERO + {4'd0, net_digit};
            S_SLASH:   emit_char = CHAR_SLASH;
            S_NODE:    emit_char = CHAR_ZERO + {4'd0, node_digit};
            S_END_CR:
            begin
                emit_char = CHAR_CR;
                emit_eot  = 1'b1;
            end
            default:   emit_char = CHAR_CR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plan_reg      <= '0;
            prev_net_reg  <= '0;
            line_len_reg  <= '0;
            at_start_reg  <= 1'b1;
            step_cnt_reg  <= '0;
            conv_sel_reg  <= 1'b0;
            head_cnt_reg  <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Conversion bookkeeping
            if (in_fire)
            begin
                step_cnt_reg <= '0;
                conv_sel_reg <= 1'b0;
            end
            else if (state_reg == S_CONV)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_CNT_W'(NUM_W - 1))
                    conv_sel_reg <= 1'b1;
            end

            // Commit the plan and the line state
            if (state_reg == S_PLAN)
            begin
                plan_reg     <= plan_next;
                prev_net_reg <= prev_net_next;
                line_len_reg <= line_len_next;
                at_start_reg <= at_start_next;
            end

            // Load segment counters on entry, advance them while emitting
            if (state_next != state_reg)
            begin
                case (state_next)
                    S_HEAD:  head_cnt_reg <= '0;
                    S_NET:   dig_cnt_reg  <= net_len - 3'd1;
                    S_NODE:  dig_cnt_reg  <= node_len - 3'd1;
                    default: ;
                endcase
            end
            else if (emitting && out_ok)
            begin
                if (state_reg == S_HEAD)
                    head_cnt_reg <= head_cnt_reg + 1'b1;
                else
                    dig_cnt_reg <= dig_cnt_reg - 3'd1;
            end

            // Output register: drop a taken beat, load a new one
            if (emitting && out_ok)
                out_valid_reg <= 1'b1;
            else if (chars.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= pairs.kind;
            last_reg  <= pairs.last_pair;
            net_reg   <= pairs.net_number;
            node_reg  <= pairs.node_number;
            shift_reg <= pairs.net_number;
            bcd_reg   <= '0;
        end
        else if (state_reg == S_CONV)
        begin
            if (!conv_sel_reg && (step_cnt_reg == STEP_CNT_W'(NUM_W - 1)))
            begin
                // Net done: keep its digits and start on the node
                net_bcd_reg <= bcd_step;
                shift_reg   <= node_reg;
                bcd_reg     <= '0;
            end
            else
            begin
                bcd_reg   <= bcd_step;
                shift_reg <= {shift_reg[NUM_W-2:0], 1'b0};
            end
        end

        if (emitting && out_ok)
        begin
            out_char_reg <= emit_char;
            out_eot_reg  <= emit_eot;
            out_last_reg <= seg_done && (state_next == S_IDLE);
        end
    end

    assign chars.valid        = out_valid_reg;
    assign chars.out_char     = out_char_reg;
    assign chars.last_of_item = out_last_reg;
    assign chars.end_of_text  = out_eot_reg;

    // The closing CR of a text is always a CR and always ends its item
    a_eot_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_eot_reg |-> (out_char_reg == CHAR_CR) && out_last_reg)
        else $error("end of text on a character other than the closing CR");

    // Node conversion finishing hands over to planning
    a_conv_to_plan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) && conv_sel_reg && (step_cnt_reg == STEP_CNT_W'(NUM_W - 1))
        |=> (state_reg == S_PLAN))
        else $error("conversion did not hand over to planning");

    // Converted digits are decimal
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_NET) |-> (net_digit <= 4'd9)) and
        ((state_reg == S_NODE) |-> (node_digit <= 4'd9)))
        else $error("non-decimal digit emitted");

    // Heading index stays within the heading in use
    a_head_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD) |-> ({1'b0, head_cnt_reg} < head_used))
        else $error("heading index past heading length");

    // A beat marked last returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emitting && out_ok && seg_done && (state_next == S_IDLE) |=> out_last_reg && pairs.ready)
        else $error("final character not flagged or block not idle");

endmodule
